// File: hw/rtl/veh_pkg.sv
// Shared types and constants for the variable-edge histogram.
// Holds request/response payloads, opcodes, controller states and command/status structs.
// No dependencies.
`default_nettype none

package veh_pkg;

  // fixed field widths
  localparam int IDX_W = 9;
  localparam int VAL_W = 32;
  localparam int BIN_W = 8;
  localparam int CNT_W = 32;
  localparam int CFG_W = 9;

  typedef enum logic [1:0] {
    OP_WRITE_EDGE = 2'd0,
    OP_COUNT      = 2'd1,
    OP_READ       = 2'd2,
    OP_CLEAR      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK          = 2'd0,
    STAT_OUT_OF_EDGE = 2'd1,
    STAT_BAD_INDEX   = 2'd2
  } status_t;

  typedef struct packed {
    op_t                     opcode;
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] sample_value;
  } in_req_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [CNT_W-1:0] count;
    status_t          status;
  } out_rsp_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_EDGE_WR,
    S_LO_CHK,
    S_HI_CHK,
    S_SEARCH,
    S_CNT_UPD,
    S_RD_REQ,
    S_RD_WAIT,
    S_CLEAR,
    S_DONE
  } state_t;

  // edge table read address select
  typedef enum logic [1:0] {
    ERD_ZERO,
    ERD_TOP,
    ERD_MID_INIT,
    ERD_MID_NEXT
  } erd_sel_t;

  // counter read address select
  typedef enum logic {
    CRD_INDEX,
    CRD_BIN
  } crd_sel_t;

  // counter write address/data select
  typedef enum logic {
    CWR_SWEEP,
    CWR_BIN
  } cwr_sel_t;

  // result register load select
  typedef enum logic [2:0] {
    RES_HOLD,
    RES_OK,
    RES_REJECT,
    RES_BAD_INDEX,
    RES_COUNT,
    RES_READ
  } res_sel_t;

  typedef struct packed {
    logic     load_req;
    logic     edge_rd_en;
    erd_sel_t erd_sel;
    logic     edge_wr_en;
    logic     search_init;
    logic     search_step;
    logic     cnt_rd_en;
    crd_sel_t crd_sel;
    logic     cnt_wr_en;
    cwr_sel_t cwr_sel;
    logic     sweep_step;
    res_sel_t res_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic key_below;
    logic search_done;
    logic index_wr_ok;
    logic index_rd_ok;
    logic sweep_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/veh_ctrl.sv
// Controller state machine for the variable-edge histogram.
// Sequences edge writes, range checks, binary search, counter updates, counter reads and clears.
// Depends on veh_pkg.
`default_nettype none

module veh_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire veh_pkg::op_t in_op,
  output logic              in_ready,
  input  wire veh_pkg::sts_t sts,
  output veh_pkg::cmd_t     cmd
);

  veh_pkg::state_t state_r;
  veh_pkg::state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= veh_pkg::S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      veh_pkg::S_INIT: begin
        if (sts.sweep_last) state_nxt = veh_pkg::S_IDLE;
      end
      veh_pkg::S_IDLE: begin
        if (in_valid) begin
          case (in_op)
            veh_pkg::OP_WRITE_EDGE: state_nxt = veh_pkg::S_EDGE_WR;
            veh_pkg::OP_COUNT:      state_nxt = veh_pkg::S_LO_CHK;
            veh_pkg::OP_READ:       state_nxt = veh_pkg::S_RD_REQ;
            default:                state_nxt = veh_pkg::S_CLEAR;
          endcase
        end
      end
      veh_pkg::S_EDGE_WR: state_nxt = veh_pkg::S_DONE;
      veh_pkg::S_LO_CHK: begin
        state_nxt = sts.key_below ? veh_pkg::S_DONE : veh_pkg::S_HI_CHK;
      end
      veh_pkg::S_HI_CHK: begin
        state_nxt = sts.key_below ? veh_pkg::S_SEARCH : veh_pkg::S_DONE;
      end
      veh_pkg::S_SEARCH: begin
        if (sts.search_done) state_nxt = veh_pkg::S_CNT_UPD;
      end
      veh_pkg::S_CNT_UPD: state_nxt = veh_pkg::S_DONE;
      veh_pkg::S_RD_REQ: begin
        state_nxt = sts.index_rd_ok ? veh_pkg::S_RD_WAIT : veh_pkg::S_DONE;
      end
      veh_pkg::S_RD_WAIT: state_nxt = veh_pkg::S_DONE;
      veh_pkg::S_CLEAR: begin
        if (sts.sweep_last) state_nxt = veh_pkg::S_DONE;
      end
      veh_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = veh_pkg::S_IDLE;
      end
      default: state_nxt = veh_pkg::S_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      veh_pkg::S_INIT: begin
        cmd.cnt_wr_en  = 1'b1;
        cmd.cwr_sel    = veh_pkg::CWR_SWEEP;
        cmd.sweep_step = 1'b1;
      end
      veh_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req   = 1'b1;
          cmd.edge_rd_en = 1'b1;
          cmd.erd_sel    = veh_pkg::ERD_ZERO;
        end
      end
      veh_pkg::S_EDGE_WR: begin
        if (sts.index_wr_ok) begin
          cmd.edge_wr_en = 1'b1;
          cmd.res_sel    = veh_pkg::RES_OK;
        end else begin
          cmd.res_sel = veh_pkg::RES_BAD_INDEX;
        end
      end
      veh_pkg::S_LO_CHK: begin
        if (sts.key_below) begin
          cmd.res_sel = veh_pkg::RES_REJECT;
        end else begin
          cmd.edge_rd_en = 1'b1;
          cmd.erd_sel    = veh_pkg::ERD_TOP;
        end
      end
      veh_pkg::S_HI_CHK: begin
        if (!sts.key_below) begin
          cmd.res_sel = veh_pkg::RES_REJECT;
        end else begin
          cmd.search_init = 1'b1;
          cmd.edge_rd_en  = 1'b1;
          cmd.erd_sel     = veh_pkg::ERD_MID_INIT;
        end
      end
      veh_pkg::S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_done) begin
          cmd.cnt_rd_en = 1'b1;
          cmd.crd_sel   = veh_pkg::CRD_BIN;
        end else begin
          cmd.edge_rd_en = 1'b1;
          cmd.erd_sel    = veh_pkg::ERD_MID_NEXT;
        end
      end
      veh_pkg::S_CNT_UPD: begin
        cmd.cnt_wr_en = 1'b1;
        cmd.cwr_sel   = veh_pkg::CWR_BIN;
        cmd.res_sel   = veh_pkg::RES_COUNT;
      end
      veh_pkg::S_RD_REQ: begin
        if (sts.index_rd_ok) begin
          cmd.cnt_rd_en = 1'b1;
          cmd.crd_sel   = veh_pkg::CRD_INDEX;
        end else begin
          cmd.res_sel = veh_pkg::RES_BAD_INDEX;
        end
      end
      veh_pkg::S_RD_WAIT: begin
        cmd.res_sel = veh_pkg::RES_READ;
      end
      veh_pkg::S_CLEAR: begin
        cmd.cnt_wr_en  = 1'b1;
        cmd.cwr_sel    = veh_pkg::CWR_SWEEP;
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) cmd.res_sel = veh_pkg::RES_OK;
      end
      veh_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/veh_datapath.sv
// Datapath for the variable-edge histogram: edge table, counter memory,
// search bounds, clearing sweep, config register and output register.
// Depends on veh_pkg; driven by veh_ctrl commands.
`default_nettype none

module veh_datapath #(
  parameter int MAX_BINS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire veh_pkg::in_req_t             in_req,
  input  wire logic                         cfg_wr_en,
  input  wire logic [veh_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire veh_pkg::cmd_t                cmd,
  output veh_pkg::sts_t                     sts,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output veh_pkg::out_rsp_t                 out_rsp
);

  localparam int EDEPTH = MAX_BINS + 1;
  localparam int EAW    = $clog2(MAX_BINS + 1);
  localparam int BAW    = $clog2(MAX_BINS);
  localparam int PW     = $clog2(MAX_BINS + 2);
  localparam logic [31:0] MAXB = 32'(MAX_BINS);
  localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

  // memories
  logic [VALUE_BITS-1:0]        edge_mem [EDEPTH];
  logic [veh_pkg::CNT_W-1:0]    cnt_mem  [MAX_BINS];

  // registers
  logic [veh_pkg::CFG_W-1:0]    bin_count_r;
  veh_pkg::op_t                 op_r;
  logic [veh_pkg::IDX_W-1:0]    idx_r;
  logic [VALUE_BITS-1:0]        key_r;
  logic [VALUE_BITS-1:0]        edge_q_r;
  logic [veh_pkg::CNT_W-1:0]    cnt_q_r;
  logic [PW-1:0]                lo_r;
  logic [PW-1:0]                hi_r;
  logic [EAW-1:0]               mid_r;
  logic [BAW-1:0]               sweep_r;
  veh_pkg::out_rsp_t            res_r;
  veh_pkg::out_rsp_t            res_nxt;
  veh_pkg::out_rsp_t            out_rsp_r;
  logic                         out_valid_r;

  // combinational
  logic [VALUE_BITS-1:0]        key_in;
  logic [PW-1:0]                nb;
  logic [PW-1:0]                nb_p1;
  logic                         below;
  logic [PW-1:0]                lo_n;
  logic [PW-1:0]                hi_n;
  logic [PW:0]                  mid_sum;
  logic [PW-1:0]                span;
  logic [EAW-1:0]               erd_addr;
  logic [BAW-1:0]               crd_addr;
  logic [BAW-1:0]               cwr_addr;
  logic [veh_pkg::CNT_W-1:0]    cwr_data;
  logic [veh_pkg::CNT_W-1:0]    cnt_inc;

  // order-preserving key: flip the sign bit so an unsigned compare works
  assign key_in = VALUE_BITS'($unsigned(in_req.sample_value)) ^ SIGN_BIT;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= veh_pkg::CFG_W'(2);
    end else if (cfg_wr_en) begin
      bin_count_r <= cfg_wr_data;
    end
  end

  // bins in use, clamped to 2..MAX_BINS
  always_comb begin
    if (32'(bin_count_r) < 32'd2) begin
      nb = PW'(2);
    end else if (32'(bin_count_r) > MAXB) begin
      nb = PW'(MAX_BINS);
    end else begin
      nb = PW'(bin_count_r);
    end
  end
  assign nb_p1 = nb + PW'(1);

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      op_r  <= in_req.opcode;
      idx_r <= in_req.index;
      key_r <= key_in;
    end
  end

  // search step: narrow [lo, hi) around the edge just read at mid
  assign below   = key_r < edge_q_r;
  assign lo_n    = below ? lo_r : PW'(mid_r);
  assign hi_n    = below ? PW'(mid_r) : hi_r;
  assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
  assign span    = hi_n - lo_n;

  always_ff @(posedge clk) begin
    if (cmd.search_init) begin
      lo_r <= '0;
      hi_r <= nb_p1;
    end else if (cmd.search_step) begin
      lo_r <= lo_n;
      hi_r <= hi_n;
    end
  end

  // edge table address select
  always_comb begin
    case (cmd.erd_sel)
      veh_pkg::ERD_ZERO:     erd_addr = '0;
      veh_pkg::ERD_TOP:      erd_addr = EAW'(nb);
      veh_pkg::ERD_MID_INIT: erd_addr = EAW'(nb_p1 >> 1);
      veh_pkg::ERD_MID_NEXT: erd_addr = EAW'(mid_sum[PW:1]);
      default:               erd_addr = '0;
    endcase
  end

  // edge table, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.edge_wr_en) begin
      edge_mem[EAW'(idx_r)] <= key_r;
    end
    if (cmd.edge_rd_en) begin
      edge_q_r <= edge_mem[erd_addr];
      mid_r    <= erd_addr;
    end
  end

  // counter memory address/data select
  assign crd_addr = (cmd.crd_sel == veh_pkg::CRD_BIN) ? BAW'(lo_n) : BAW'(idx_r);
  assign cnt_inc  = (cnt_q_r == '1) ? cnt_q_r : cnt_q_r + 1'b1;

  always_comb begin
    if (cmd.cwr_sel == veh_pkg::CWR_BIN) begin
      cwr_addr = BAW'(lo_r);
      cwr_data = cnt_inc;
    end else begin
      cwr_addr = sweep_r;
      cwr_data = '0;
    end
  end

  // counter memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.cnt_wr_en) begin
      cnt_mem[cwr_addr] <= cwr_data;
    end
    if (cmd.cnt_rd_en) begin
      cnt_q_r <= cnt_mem[crd_addr];
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.load_req) begin
      sweep_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_r <= sweep_r + 1'b1;
    end
  end

  // result select
  always_comb begin
    res_nxt = res_r;
    case (cmd.res_sel)
      veh_pkg::RES_OK: begin
        res_nxt.bin_index = '0;
        res_nxt.count     = '0;
        res_nxt.status    = veh_pkg::STAT_OK;
      end
      veh_pkg::RES_REJECT: begin
        res_nxt.bin_index = '0;
        res_nxt.count     = '0;
        res_nxt.status    = veh_pkg::STAT_OUT_OF_EDGE;
      end
      veh_pkg::RES_BAD_INDEX: begin
        res_nxt.bin_index = '0;
        res_nxt.count     = '0;
        res_nxt.status    = veh_pkg::STAT_BAD_INDEX;
      end
      veh_pkg::RES_COUNT: begin
        res_nxt.bin_index = veh_pkg::BIN_W'(lo_r);
        res_nxt.count     = cnt_inc;
        res_nxt.status    = veh_pkg::STAT_OK;
      end
      veh_pkg::RES_READ: begin
        res_nxt.bin_index = veh_pkg::BIN_W'(idx_r);
        res_nxt.count     = cnt_q_r;
        res_nxt.status    = veh_pkg::STAT_OK;
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rsp_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // status back to the controller
  always_comb begin
    sts             = '0;
    sts.key_below   = below;
    sts.search_done = (span <= PW'(1));
    sts.index_wr_ok = (32'(idx_r) <= MAXB) && (op_r == veh_pkg::OP_WRITE_EDGE);
    sts.index_rd_ok = (32'(idx_r) < 32'(nb));
    sts.sweep_last  = (sweep_r == BAW'(MAX_BINS - 1));
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

`default_nettype wire

// File: hw/rtl/variable_edge_histogram.sv
// Top level of the variable-edge histogram: controller plus datapath.
// Depends on veh_pkg, veh_ctrl and veh_datapath.
//
//   channel   ports                          direction  handshake
//   request   in_valid / in_ready / in_req   in         valid-ready
//   result    out_valid / out_ready / out_rsp out        valid-ready
//   config    cfg_wr_en / cfg_wr_data        in         write enable, no wait
//
// One request at a time; in_ready is high only while the controller is idle.
// A count request is paced by the binary search loop, one registered edge-table
//   read per step; a sample outside the edge range ends at the low or high
//   edge check without a search.
// A clear zeroes one counter per cycle through the single write port.
// After reset a clearing pass zeroes the counters; no request is taken
//   meanwhile, config writes are.
// A result waits in the output register; a stalled out_ready holds the
//   controller in its final state until the register frees.
`default_nettype none

module variable_edge_histogram #(
  parameter int MAX_BINS   = 256,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire veh_pkg::in_req_t           in_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output veh_pkg::out_rsp_t               out_rsp,
  input  wire logic                       cfg_wr_en,
  input  wire logic [veh_pkg::CFG_W-1:0]  cfg_wr_data
);

  veh_pkg::cmd_t cmd;
  veh_pkg::sts_t sts;

  // controller
  veh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_req.opcode),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  veh_datapath #(
    .MAX_BINS   (MAX_BINS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_rsp     (out_rsp)
  );

  // a new result only comes from the controller's final step
  a_out_from_load: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.out_load)
  ) else $error("result appeared without a load");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready)
  ) else $error("output register overwritten");

  // one request in flight: not ready right after an accept
  a_one_in_flight: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready
  ) else $error("second request accepted while busy");

  // counter memory is never read and written in the same cycle
  a_cnt_port: assert property (
    @(posedge clk) disable iff (!rst_n)
    cmd.cnt_wr_en |-> !cmd.cnt_rd_en
  ) else $error("counter read and write collide");

endmodule

`default_nettype wire

// File: bench/variable_edge_histogram_test.sv
// Self-checking bench for the variable-edge histogram: a directed table, then random phases
// that reload the bin edges under different bin_count settings.
// Depends on veh_pkg and the variable_edge_histogram RTL; results come from a local predictor.
`timescale 1ns / 1ps

module variable_edge_histogram_test;
  import veh_pkg::*;

  localparam int MAX_BINS     = 256;
  localparam int NUM_ROWS     = 24;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CALM_ITEMS   = 1050;
  localparam int DRAIN_CYCLES = 300;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int REPORT_MAX   = 10;

  localparam logic [VAL_W-1:0] VAL_MIN   = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX   = 32'h7FFF_FFFF;
  localparam longint           VAL_FLOOR = -64'sd2147483648;

  typedef struct packed {
    in_req_t  req;
    logic     typed;
    out_rsp_t rsp;
  } stim_row_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  in_req_t          in_req      = '0;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  out_rsp_t         out_rsp;
  logic             cfg_wr_en   = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;

  // predictor state: edge values, which edges hold a value, bin counters, bin_count
  logic signed [VAL_W-1:0] bounds      [0:MAX_BINS];
  bit                      bound_known [0:MAX_BINS];
  logic [CNT_W-1:0]        bin_hits    [0:MAX_BINS-1];
  logic [CFG_W-1:0]        live_bins = 9'd2;

  out_rsp_t    awaited_rsp [$];
  out_rsp_t    want_rsp;
  stim_row_t   dir_rows [0:NUM_ROWS-1];
  int          rand_items  = 0;
  int          sent_count  = 0;
  int          phase_count = 0;
  int          fault_count = 0;
  int          ok_count    = 0;
  int          reject_count = 0;
  int          bad_count   = 0;
  int          ready_left  = 0;
  int unsigned cycle_count = 0;
  wire         calm = (rand_items >= CALM_ITEMS);

  variable_edge_histogram #(
    .MAX_BINS   (MAX_BINS),
    .VALUE_BITS (VAL_W)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req      (in_req),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_rsp     (out_rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // out-of-range bin_count clamps to 2..MAX_BINS
  function automatic int effective_bins();
    if (live_bins < 2) return 2;
    if (live_bins > MAX_BINS) return MAX_BINS;
    return int'(live_bins);
  endfunction

  // result of one request, updating edges and counters
  function automatic out_rsp_t histogram_step(in_req_t req);
    out_rsp_t                rsp;
    int                      nb, lo, hi, mid, b;
    logic signed [VAL_W-1:0] val;
    nb  = effective_bins();
    val = req.sample_value;
    rsp = '0;
    rsp.status = STAT_OK;
    case (req.opcode)
      OP_WRITE_EDGE: begin
        if (req.index <= MAX_BINS) begin
          bounds[req.index]      = val;
          bound_known[req.index] = 1'b1;
        end else begin
          rsp.status = STAT_BAD_INDEX;
        end
      end
      OP_COUNT: begin
        if (val < bounds[0] || val >= bounds[nb]) begin
          rsp.status = STAT_OUT_OF_EDGE;
        end else begin
          // binary search for bounds[lo] <= val < bounds[lo+1]
          lo = 0;
          hi = nb + 1;
          while (hi - lo > 1) begin
            mid = (lo + hi) / 2;
            if (val < bounds[mid]) hi = mid;
            else lo = mid;
          end
          if (bin_hits[lo] != '1) bin_hits[lo] = bin_hits[lo] + 1'b1;
          rsp.bin_index = lo[BIN_W-1:0];
          rsp.count     = bin_hits[lo];
        end
      end
      OP_READ: begin
        if (req.index < nb) begin
          rsp.bin_index = req.index[BIN_W-1:0];
          rsp.count     = bin_hits[req.index];
        end else begin
          rsp.status = STAT_BAD_INDEX;
        end
      end
      default: begin
        for (b = 0; b < MAX_BINS; b++) bin_hits[b] = '0;
      end
    endcase
    return rsp;
  endfunction

  function automatic stim_row_t row(op_t op, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                                    logic typed, logic [BIN_W-1:0] bin,
                                    logic [CNT_W-1:0] cnt, status_t st);
    stim_row_t r;
    r.req.opcode       = op;
    r.req.index        = idx;
    r.req.sample_value = val;
    r.typed            = typed;
    r.rsp.bin_index    = bin;
    r.rsp.count        = cnt;
    r.rsp.status       = st;
    return r;
  endfunction

  // one request, with an optional idle burst ahead of it
  task automatic send_request(input in_req_t req, input logic typed, input out_rsp_t typed_rsp);
    out_rsp_t rsp;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp = histogram_step(req);
    awaited_rsp.push_back(typed ? typed_rsp : rsp);
    sent_count++;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle(input int extra);
    in_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_bin_count(input logic [CFG_W-1:0] value);
    settle(4);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    live_bins    = value;
    phase_count++;
  endtask

  // new bin_count, edge table load where needed, then mixed requests
  task automatic run_phase(input logic [CFG_W-1:0] setting);
    int              nb, ops, style, pick, k, i;
    bit              fresh;
    int unsigned     step_max;
    longint          acc, lo_val, span;
    longint unsigned rnd;
    in_req_t         req;
    set_bin_count(setting);
    nb    = effective_bins();
    fresh = (nb <= 32) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) == 0);
    for (i = 0; i <= nb; i++) begin
      if (!bound_known[i]) fresh = 1'b1;
    end

    // edge load: wide ascending, narrow steps with repeats, or scrambled
    if (fresh) begin
      style    = $urandom_range(0, 19);
      step_max = 32'hFFFF_FFFF / (nb + 1);
      if (style < 14) acc = VAL_FLOOR + longint'($urandom_range(0, step_max));
      else acc = VAL_FLOOR + longint'($urandom_range(0, 32'hFFFF_0000));
      for (i = 0; i <= nb; i++) begin
        if (style >= 17) acc = $urandom;
        req              = '0;
        req.opcode       = OP_WRITE_EDGE;
        req.index        = IDX_W'(i);
        req.sample_value = acc[VAL_W-1:0];
        send_request(req, 1'b0, '0);
        rand_items++;
        if (style < 14) acc += longint'($urandom_range(1, step_max));
        else if (style < 17) acc += longint'($urandom_range(0, 3));
      end
    end

    ops = $urandom_range(30, 100);
    for (k = 0; k < ops; k++) begin
      pick             = $urandom_range(0, 99);
      req.index        = IDX_W'($urandom_range(0, 511));
      req.sample_value = $urandom;
      if (pick < 60) begin
        // sample next to an edge, or anywhere inside the edge range
        req.opcode = OP_COUNT;
        if ($urandom_range(0, 1) == 0) begin
          i = $urandom_range(0, nb);
          req.sample_value = bounds[i] + ($urandom_range(0, 4) - 2);
        end else begin
          lo_val = bounds[0];
          span   = longint'(bounds[nb]) - lo_val;
          rnd    = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
          if (span > 0) req.sample_value = 32'(lo_val + longint'(rnd % span));
        end
      end else if (pick < 77) begin
        req.opcode = OP_READ;
        if ($urandom_range(0, 6) != 0) req.index = IDX_W'($urandom_range(0, nb - 1));
      end else if (pick < 80) begin
        req.opcode = OP_CLEAR;
      end else if (pick < 90) begin
        req.opcode = OP_WRITE_EDGE;
      end else begin
        // raw sample, mostly outside the range
        req.opcode = OP_COUNT;
      end
      send_request(req, 1'b0, '0);
      rand_items++;
    end
  endtask

  // result side stalls: out_ready bursts low between ready stretches, held high once calm
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left > 1) begin
      ready_left <= ready_left - 1;
    end else if (out_ready && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_left <= $urandom_range(1, 9);
    end else begin
      out_ready  <= 1'b1;
      ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
    end
  end

  // compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_rsp.size() == 0) begin
        if (fault_count < REPORT_MAX)
          $display("unexpected result: bin %0d count %0d status %0d",
                   out_rsp.bin_index, out_rsp.count, out_rsp.status);
        fault_count++;
      end else begin
        want_rsp = awaited_rsp.pop_front();
        if (out_rsp.bin_index !== want_rsp.bin_index || out_rsp.count !== want_rsp.count ||
            out_rsp.status !== want_rsp.status) begin
          if (fault_count < REPORT_MAX)
            $display("mismatch: expected bin %0d count %0d status %0d, got bin %0d count %0d status %0d",
                     want_rsp.bin_index, want_rsp.count, want_rsp.status,
                     out_rsp.bin_index, out_rsp.count, out_rsp.status);
          fault_count++;
        end
        case (want_rsp.status)
          STAT_OK:          ok_count++;
          STAT_OUT_OF_EDGE: reject_count++;
          default:          bad_count++;
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results outstanding",
               cycle_count, awaited_rsp.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int               r;
    logic [CFG_W-1:0] setting;
    logic [CFG_W-1:0] plan [0:6];
    plan = '{9'd511, 9'd0, 9'd1, 9'd257, 9'd256, 9'd2, 9'd3};
    for (r = 0; r <= MAX_BINS; r++) bounds[r] = '0;
    for (r = 0; r < MAX_BINS; r++) bin_hits[r] = '0;

    // directed rows at the reset bin_count of 2
    dir_rows[0]  = row(OP_WRITE_EDGE, 9'd0,   VAL_MIN,      1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[1]  = row(OP_WRITE_EDGE, 9'd1,   32'd0,        1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[2]  = row(OP_WRITE_EDGE, 9'd2,   VAL_MAX,      1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[3]  = row(OP_COUNT,      9'd0,   VAL_MIN,      1'b1, 8'd0, 32'd1, STAT_OK);
    dir_rows[4]  = row(OP_COUNT,      9'd0,   32'hFFFF_FFFF, 1'b1, 8'd0, 32'd2, STAT_OK);
    dir_rows[5]  = row(OP_COUNT,      9'd0,   32'd0,        1'b1, 8'd1, 32'd1, STAT_OK);
    dir_rows[6]  = row(OP_COUNT,      9'd0,   VAL_MAX - 1,  1'b1, 8'd1, 32'd2, STAT_OK);
    dir_rows[7]  = row(OP_COUNT,      9'd0,   VAL_MAX,      1'b1, 8'd0, 32'd0, STAT_OUT_OF_EDGE);
    dir_rows[8]  = row(OP_READ,       9'd0,   32'd0,        1'b1, 8'd0, 32'd2, STAT_OK);
    dir_rows[9]  = row(OP_READ,       9'd1,   32'd0,        1'b1, 8'd1, 32'd2, STAT_OK);
    dir_rows[10] = row(OP_READ,       9'd2,   32'd0,        1'b1, 8'd0, 32'd0, STAT_BAD_INDEX);
    dir_rows[11] = row(OP_READ,       9'd511, 32'd0,        1'b1, 8'd0, 32'd0, STAT_BAD_INDEX);
    dir_rows[12] = row(OP_WRITE_EDGE, 9'd257, 32'd5,        1'b1, 8'd0, 32'd0, STAT_BAD_INDEX);
    dir_rows[13] = row(OP_WRITE_EDGE, 9'd511, -32'sd5,      1'b1, 8'd0, 32'd0, STAT_BAD_INDEX);
    dir_rows[14] = row(OP_WRITE_EDGE, 9'd256, 32'd123,      1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[15] = row(OP_CLEAR,      9'd511, 32'hFFFF_FFFF, 1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[16] = row(OP_READ,       9'd1,   32'd0,        1'b1, 8'd1, 32'd0, STAT_OK);
    dir_rows[17] = row(OP_WRITE_EDGE, 9'd0,   -32'sd100,    1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[18] = row(OP_COUNT,      9'd0,   -32'sd101,    1'b1, 8'd0, 32'd0, STAT_OUT_OF_EDGE);
    dir_rows[19] = row(OP_COUNT,      9'd0,   -32'sd100,    1'b1, 8'd0, 32'd1, STAT_OK);
    // edge 1 below edge 0: search runs on an out-of-order table
    dir_rows[20] = row(OP_WRITE_EDGE, 9'd1,   -32'sd200,    1'b1, 8'd0, 32'd0, STAT_OK);
    dir_rows[21] = row(OP_COUNT,      9'd0,   32'd50,       1'b0, 8'd0, 32'd0, STAT_OK);
    dir_rows[22] = row(OP_COUNT,      9'd511, -32'sd50,     1'b0, 8'd0, 32'd0, STAT_OK);
    dir_rows[23] = row(OP_READ,       9'd0,   32'd0,        1'b1, 8'd0, 32'd1, STAT_OK);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < NUM_ROWS; r++)
      send_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].rsp);

    // extremes of bin_count first, then mostly small settings
    r = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (r < 7) begin
        setting = plan[r];
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5, 6: setting = CFG_W'($urandom_range(2, 20));
          7, 8:                setting = CFG_W'($urandom_range(21, 255));
          default:             setting = CFG_W'($urandom_range(0, 511));
        endcase
      end
      r++;
      run_phase(setting);
    end

    settle(DRAIN_CYCLES);
    $display("%0d requests (%0d directed) over %0d bin_count settings in %0d cycles",
             sent_count, NUM_ROWS, phase_count, cycle_count);
    $display("results: %0d ok, %0d outside edge range, %0d bad index, %0d mismatches",
             ok_count, reject_count, bad_count, fault_count);
    if (fault_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/veh_pkg.sv
hw/rtl/veh_ctrl.sv
hw/rtl/veh_datapath.sv
hw/rtl/variable_edge_histogram.sv
bench/variable_edge_histogram_test.sv
